// ----- design/ph_sample_median_window_unit_macros.svh -----
// assertion macros shared by the median window design
`ifndef PH_SAMPLE_MEDIAN_WINDOW_UNIT_MACROS_SVH
`define PH_SAMPLE_MEDIAN_WINDOW_UNIT_MACROS_SVH

// check that an antecedent implies a consequent on the same edge
`define PSM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// check that an antecedent implies a consequent on the next edge
`define PSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// check a condition at every edge out of reset
`define PSM_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

// ----- design/psm_pkg.sv -----
package psm_pkg;

   localparam int unsigned CfgIndexWidth = 2;
   localparam logic [CfgIndexWidth-1:0] CFG_PH_PER_VOLT     = 2'd0;
   localparam logic [CfgIndexWidth-1:0] CFG_PH_OFFSET       = 2'd1;
   localparam logic [CfgIndexWidth-1:0] CFG_NEAR_ZERO_LIMIT = 2'd2;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   localparam logic signed [15:0] PhPerVoltReset = 16'sd256;
   localparam logic signed [15:0] PhOffsetReset  = 16'sd0;
   localparam logic [11:0]        NearZeroReset  = 12'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_OUTER,
      ST_INNER,
      ST_SELECT,
      ST_DONE
   } psm_state_type;

   // control signals from the sequencer to the result stage
   typedef struct packed {
      logic       load;
      logic       accepted;
      logic       median_valid;
      logic [6:0] held_count;
   } psm_result_ctl_type;

   function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
      if (v > 34'sd32767) begin
         return 16'sh7fff;
      end else if (v < -34'sd32768) begin
         return 16'sh8000;
      end else begin
         return v[15:0];
      end
   endfunction

endpackage

// ----- design/psm_ram.sv -----
module psm_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- design/psm_result.sv -----
module psm_result (
   input  logic                        clock,
   input  logic                        reset,
   input  psm_pkg::psm_result_ctl_type ctl,
   input  logic                        is_full,
   input  logic signed [15:0]          median_ph,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [23:0]                 rsp_tdata
);
   import psm_pkg::*;

   logic        valid_ff, valid_in;
   logic [23:0] data_ff, data_in;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (rsp_tready) begin
         valid_in = 1'b0;
      end
      if (ctl.load) begin
         valid_in = 1'b1;
         data_in  = {median_ph, ctl.median_valid, is_full,
                     ctl.held_count[4:0], ctl.accepted};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
endmodule

// ----- design/ph_sample_median_window_unit.sv -----
// pH running median filter.
// req channel: one item per operation; tdata from bit 0: operation,
// voltage[15:0], voltage_invalid. A clear empties the window, a take sample
// converts the voltage to pH and stores it unless invalid or near zero.
// rsp channel: one item per request; tdata from bit 0: accepted,
// sample count[4:0], window_full, median_valid, median_ph[15:0].
// csr channel: index 0 ph_per_volt, 1 ph_offset, 2 near_zero_limit.
// The median is found by a rank count over the window memory: each candidate
// slot is addressed in ST_OUTER, the window is streamed through the single
// read port in ST_INNER, and its rank is checked in ST_SELECT. Slots are
// scanned until both middle values are found (at most WINDOW_DEPTH slots).
// A stored sample is first converted and written, other samples start the
// scan at once, and a clear or an empty window skips it. One item is in
// flight at a time.
// Reset empties the window and restores the register defaults; no clearing
// pass is needed, slot valid bits live in flip-flops.
// The result sits in an output register; while it is held under a stall no
// new item is taken.
module ph_sample_median_window_unit #(
   parameter int unsigned WINDOW_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // operation, voltage[15:0], voltage_invalid
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // accepted, sample_cnt[4:0], window_full,
                                    // median_valid, median_ph[15:0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import psm_pkg::*;
`include "ph_sample_median_window_unit_macros.svh"

   localparam int unsigned AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int unsigned CW = 7;
   localparam logic [CW-1:0] DepthC = CW'(WINDOW_DEPTH);
   // product register value once the converted sample is stored
   localparam logic signed [31:0] ProdStored = 32'sh7fffffff;

   psm_state_type state_ff, state_in;

   logic signed [15:0] gain_ff, gain_in, offset_ff, offset_in;
   logic [11:0]        limit_ff, limit_in;

   logic [WINDOW_DEPTH-1:0] filled_ff, filled_in;
   logic [AW-1:0]           wslot_ff, wslot_in;
   logic [CW-1:0]           count_ff, count_in;

   logic signed [15:0] volt_ff, volt_in;
   logic               acc_ff, acc_in;
   logic signed [31:0] prod_ff, prod_in;

   // rank search: candidate index i, scan index j
   logic [AW-1:0]      ci_ff, ci_in, cj_ff, cj_in;
   logic               jv_ff, jv_in;   // read data for cj valid
   logic signed [15:0] cand_ff, cand_in;
   logic [CW-1:0]      less_ff, less_in, leq_ff, leq_in;
   logic               lo_found_ff, lo_found_in, hi_found_ff, hi_found_in;
   logic signed [15:0] lo_ff, lo_in, hi_ff, hi_in;
   logic               cand_load_ff, cand_load_in;

   logic               ram_we;
   logic [AW-1:0]      ram_waddr, ram_raddr;
   logic signed [15:0] ram_wdata, ram_rdata;

   psm_result_ctl_type rctl;
   logic signed [15:0] med_out;
   logic signed [16:0] med_sum;

   logic               req_op, req_inv;
   logic signed [15:0] req_volt;
   logic [16:0]        mag;
   logic               take;
   logic               store_now;
   logic [CW-1:0]      rank_lo, rank_hi;

   assign req_op   = req_tdata[0];
   assign req_volt = req_tdata[16:1];
   assign req_inv  = req_tdata[17];
   assign mag      = req_volt[15] ? (17'd0 - {req_volt[15], req_volt})
                                  : {1'b0, req_volt};
   assign take     = (req_op == OP_SAMPLE) && !req_inv && (mag >= {5'd0, limit_ff});

   assign req_tready = (state_ff == ST_IDLE) && !(rsp_tvalid && !rsp_tready);
   assign csr_ready  = 1'b1;

   // a take stores its converted sample on the first pass through outer
   assign store_now = (state_ff == ST_OUTER) && acc_ff && (prod_ff != ProdStored);

   // middle ranks: lo = (n-1)/2, hi = n/2
   assign rank_lo = (count_ff - CW'(1)) >> 1;
   assign rank_hi = count_ff >> 1;

   psm_ram #(.WIDTH(16), .DEPTH(WINDOW_DEPTH)) u_window (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      gain_in   = gain_ff;
      offset_in = offset_ff;
      limit_in  = limit_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CFG_PH_PER_VOLT:     gain_in   = csr_data;
            CFG_PH_OFFSET:       offset_in = csr_data;
            CFG_NEAR_ZERO_LIMIT: limit_in  = csr_data[11:0];
            default:             ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               if (take) begin
                  state_in = ST_CONVERT;
               end else if (req_op == OP_CLEAR || count_ff == '0) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_OUTER;
               end
            end
         end
         ST_CONVERT: state_in = ST_OUTER;
         ST_OUTER:   state_in = store_now ? ST_OUTER : ST_INNER;
         ST_INNER: begin
            if (cj_ff == AW'(WINDOW_DEPTH - 1) && jv_ff) begin
               state_in = ST_SELECT;
            end
         end
         ST_SELECT: begin
            if ((lo_found_in && hi_found_in) || ci_ff == AW'(WINDOW_DEPTH - 1)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_OUTER;
            end
         end
         ST_DONE:    state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      logic signed [33:0] ph_wide;
      logic               jf;
      filled_in    = filled_ff;
      wslot_in     = wslot_ff;
      count_in     = count_ff;
      volt_in      = volt_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      ci_in        = ci_ff;
      cj_in        = cj_ff;
      jv_in        = 1'b0;
      cand_in      = cand_ff;
      less_in      = less_ff;
      leq_in       = leq_ff;
      lo_found_in  = lo_found_ff;
      hi_found_in  = hi_found_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      cand_load_in = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = wslot_ff;
      ram_wdata    = '0;
      ram_raddr    = cj_ff;
      rctl         = '0;
      ph_wide      = '0;
      jf           = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            ci_in       = '0;
            lo_found_in = 1'b0;
            hi_found_in = 1'b0;
            if (req_tvalid && req_tready) begin
               volt_in = req_volt;
               acc_in  = take;
               if (req_op == OP_CLEAR) begin
                  filled_in = '0;
                  wslot_in  = '0;
                  count_in  = '0;
               end
            end
         end
         ST_CONVERT: begin
            prod_in = volt_ff * gain_ff;
         end
         ST_OUTER: begin
            ram_raddr    = ci_ff;
            cj_in        = '0;
            less_in      = '0;
            leq_in       = '0;
            cand_load_in = !store_now;
            if (store_now) begin
               // finish conversion and store; the scan restarts with the write settled
               ph_wide   = 34'(prod_ff >>> 12) - 34'(offset_ff);
               ram_we    = 1'b1;
               ram_wdata = sat16(ph_wide);
               if (filled_ff[wslot_ff]) begin
                  wslot_in  = (wslot_ff == AW'(WINDOW_DEPTH - 1)) ? '0 : wslot_ff + AW'(1);
                  ram_waddr = wslot_in;
               end
               filled_in[ram_waddr] = 1'b1;
               if (!filled_ff[ram_waddr]) begin
                  count_in = count_ff + CW'(1);
               end
               prod_in = ProdStored;
            end
         end
         ST_INNER: begin
            if (cand_load_ff) begin
               cand_in = ram_rdata;
            end
            ram_raddr = cj_ff;
            jv_in     = !jv_ff || cj_ff != AW'(WINDOW_DEPTH - 1);
            if (jv_ff) begin
               jf = filled_ff[cj_ff];
               if (jf && ram_rdata < (cand_load_ff ? ram_rdata : cand_ff)) begin
                  less_in = less_ff + CW'(1);
               end
               if (jf && ram_rdata <= (cand_load_ff ? ram_rdata : cand_ff)) begin
                  leq_in = leq_ff + CW'(1);
               end
               if (cj_ff != AW'(WINDOW_DEPTH - 1)) begin
                  cj_in = cj_ff + AW'(1);
                  ram_raddr = cj_ff + AW'(1);
               end
            end
         end
         ST_SELECT: begin
            if (filled_ff[ci_ff]) begin
               if (!lo_found_ff && less_ff <= rank_lo && rank_lo < leq_ff) begin
                  lo_found_in = 1'b1;
                  lo_in       = cand_ff;
               end
               if (!hi_found_ff && less_ff <= rank_hi && rank_hi < leq_ff) begin
                  hi_found_in = 1'b1;
                  hi_in       = cand_ff;
               end
            end
            ci_in = ci_ff + AW'(1);
         end
         ST_DONE: begin
            rctl.load         = 1'b1;
            rctl.accepted     = acc_ff;
            rctl.held_count   = count_ff;
            rctl.median_valid = (count_ff != '0);
         end
         default: ;
      endcase
   end

   assign med_sum = {hi_ff[15], hi_ff} + {lo_ff[15], lo_ff};
   assign med_out = (count_ff == '0) ? 16'sd0 : med_sum[16:1];

   psm_result u_result (
      .clock      (clock),
      .reset      (reset),
      .ctl        (rctl),
      .is_full    (count_ff == DepthC),
      .median_ph  (med_out),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gain_ff      <= PhPerVoltReset;
         offset_ff    <= PhOffsetReset;
         limit_ff     <= NearZeroReset;
         filled_ff    <= '0;
         wslot_ff     <= '0;
         count_ff     <= '0;
         jv_ff        <= 1'b0;
         cand_load_ff <= 1'b0;
         lo_found_ff  <= 1'b0;
         hi_found_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gain_ff      <= gain_in;
         offset_ff    <= offset_in;
         limit_ff     <= limit_in;
         filled_ff    <= filled_in;
         wslot_ff     <= wslot_in;
         count_ff     <= count_in;
         jv_ff        <= jv_in;
         cand_load_ff <= cand_load_in;
         lo_found_ff  <= lo_found_in;
         hi_found_ff  <= hi_found_in;
      end
      volt_ff <= volt_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      ci_ff   <= ci_in;
      cj_ff   <= cj_in;
      cand_ff <= cand_in;
      less_ff <= less_in;
      leq_ff  <= leq_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
   end

   `PSM_ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= DepthC,
      "sample count above window depth")
   `PSM_ASSERT_NEXT(a_clear_empties, clock, reset,
      req_tvalid && req_tready && req_op == OP_CLEAR, count_ff == '0,
      "clear did not empty the window")
   `PSM_ASSERT_IMP(a_no_overwrite, clock, reset, rctl.load, !(rsp_tvalid && !rsp_tready),
      "result loaded over a held item")
   `PSM_ASSERT_IMP(a_count_matches, clock, reset, state_ff == ST_IDLE,
      count_ff == CW'($countones(filled_ff)), "count differs from filled slots")
endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import psm_pkg::*;

   // register index outside the map, writes to it are dropped
   localparam logic [1:0] CFG_INDEX_UNUSED = 2'd3;

   typedef struct packed {
      logic        invalid;
      logic [15:0] volts;
      logic        op;
   } ph_req_t;

   typedef struct packed {
      logic [15:0] median;
      logic        mvalid;
      logic        full;
      logic [4:0]  count;
      logic        accepted;
   } ph_rsp_t;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [23:0] rsp_tdata;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   ph_sample_median_window_unit dut (.*);

   always #5 clock = ~clock;

   // pH converter and window shadow
   logic signed [15:0] gain_q88;
   logic signed [15:0] offset_q88;
   logic [11:0]        zero_limit;
   logic signed [15:0] win_ph [16];
   logic               win_used [16];
   int unsigned        wr_slot;

   ph_req_t pending_reqs [$];
   ph_rsp_t expected_rsps [$];
   int      errors = 0;
   int      rsp_seen = 0;
   bit      hold_sender = 0;
   int      req_gap = 0;
   int      rsp_gap = 0;

   function automatic int rand_gap();
      if ($urandom_range(0, 9) < 5) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic ph_rsp_t predict_window(ph_req_t r);
      ph_rsp_t res;
      int      mag, prod, ph, n, t, i, j;
      int      vals [16];
      res = '0;
      if (r.op == OP_CLEAR) begin
         for (i = 0; i < 16; i++) win_used[i] = 0;
         wr_slot = 0;
      end else if (!r.invalid) begin
         mag = $signed(r.volts);
         if (mag < 0) mag = -mag;
         if (mag >= zero_limit) begin
            prod = $signed(r.volts) * gain_q88;
            ph = (prod >>> 12) - offset_q88;
            if (ph > 32767) ph = 32767;
            if (ph < -32768) ph = -32768;
            if (win_used[wr_slot]) wr_slot = (wr_slot + 1) % 16;
            win_ph[wr_slot] = 16'(ph);
            win_used[wr_slot] = 1;
            res.accepted = 1;
         end
      end
      n = 0;
      for (i = 0; i < 16; i++)
         if (win_used[i]) begin
            vals[n] = win_ph[i];
            n++;
         end
      for (i = 1; i < n; i++) begin
         t = vals[i];
         j = i;
         while (j > 0 && vals[j-1] > t) begin
            vals[j] = vals[j-1];
            j--;
         end
         vals[j] = t;
      end
      res.count = 5'(n);
      res.full = (n == 16);
      if (n > 0) begin
         res.mvalid = 1;
         if (n % 2) res.median = 16'(vals[n/2]);
         else res.median = 16'((vals[n/2-1] + vals[n/2]) >>> 1);
      end
      return res;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_gap > 0 || hold_sender || pending_reqs.size() == 0) begin
            req_tvalid <= 0;
            if (req_gap > 0) req_gap <= req_gap - 1;
         end else begin
            ph_req_t r;
            r = pending_reqs.pop_front();
            expected_rsps.push_back(predict_window(r));
            req_tdata <= {6'd0, r};
            req_tvalid <= 1;
            req_gap <= rand_gap();
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            ph_rsp_t got, want;
            got = rsp_tdata;
            rsp_seen++;
            if (expected_rsps.size() == 0) begin
               $display("%0t: result with nothing expected, actual %h", $time, got);
               errors++;
            end else begin
               want = expected_rsps.pop_front();
               if (got.accepted !== want.accepted || got.count !== want.count ||
                   got.full !== want.full || got.mvalid !== want.mvalid ||
                   got.median !== want.median) begin
                  $display("%0t: mismatch expected acc %0d cnt %0d full %0d mv %0d med %0d",
                           $time, want.accepted, want.count, want.full, want.mvalid,
                           $signed(want.median));
                  $display("%0t:          actual acc %0d cnt %0d full %0d mv %0d med %0d",
                           $time, got.accepted, got.count, got.full, got.mvalid,
                           $signed(got.median));
                  errors++;
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_tready <= 0;
            rsp_gap <= rsp_gap - 1;
         end else begin
            rsp_tready <= 1;
            if ($urandom_range(0, 3) == 0) rsp_gap <= rand_gap();
         end
      end
   end

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || req_tvalid)
         @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      case (idx)
         CFG_PH_PER_VOLT: gain_q88 = val;
         CFG_PH_OFFSET: offset_q88 = val;
         CFG_NEAR_ZERO_LIMIT: zero_limit = val[11:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic add_item(logic op, logic [15:0] v, logic inv);
      ph_req_t r;
      r.op = op;
      r.volts = v;
      r.invalid = inv;
      pending_reqs.push_back(r);
   endtask

   task automatic add_random(int count);
      int k, sel;
      logic [15:0] v;
      for (k = 0; k < count; k++) begin
         sel = $urandom_range(0, 99);
         case ($urandom_range(0, 3))
            0: v = 16'($urandom);
            1: v = 16'($urandom_range(0, 40) - 20);
            2: v = $urandom_range(0, 1) ? 16'(16'h7fff - $urandom_range(0, 3))
                                         : 16'(16'h8000 + $urandom_range(0, 3));
            default: v = 16'($urandom_range(0, 8000) - 4000);
         endcase
         add_item(sel < 3 ? OP_CLEAR : OP_SAMPLE, v, sel >= 3 && sel < 10);
      end
   endtask

   initial begin
      int ph, i;
      logic [15:0] settings [5][3];
      gain_q88 = PhPerVoltReset;
      offset_q88 = PhOffsetReset;
      zero_limit = NearZeroReset;
      for (i = 0; i < 16; i++) begin
         win_used[i] = 0;
         win_ph[i] = 0;
      end
      wr_slot = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset defaults, empty-window, extremes, invalid, threshold, clear
      add_item(OP_SAMPLE, 16'd0, 0);
      add_item(OP_SAMPLE, 16'd3, 0);
      add_item(OP_SAMPLE, 16'hfffc, 0);
      add_item(OP_SAMPLE, 16'd4, 0);
      add_item(OP_SAMPLE, 16'h7fff, 0);
      add_item(OP_SAMPLE, 16'h8000, 0);
      add_item(OP_SAMPLE, 16'h1234, 1);
      add_item(OP_SAMPLE, 16'hffff, 1);
      add_item(OP_CLEAR, 16'hffff, 1);
      add_item(OP_CLEAR, 16'h0000, 0);
      for (i = 0; i < 14; i++) add_item(OP_SAMPLE, 16'(16'h0100 * (i + 1) ^ 16'h8aa5), 0);
      wait_drained();

      settings[0] = '{16'h7fff, 16'h8000, 16'd0};
      settings[1] = '{16'h8000, 16'h7fff, 16'h0fff};
      settings[2] = '{16'h0000, 16'h0000, 16'd1};
      settings[3] = '{16'hff00, 16'h0123, 16'd20};
      settings[4] = '{16'h0100, 16'h0000, 16'd4};
      for (ph = 0; ph < 5; ph++) begin
         write_reg(CFG_PH_PER_VOLT, settings[ph][0]);
         write_reg(CFG_PH_OFFSET, settings[ph][1]);
         write_reg(CFG_NEAR_ZERO_LIMIT, settings[ph][2]);
         if (ph == 2) write_reg(CFG_INDEX_UNUSED, 16'hffff);
         add_random(95);
         // sender holds off mid-stream until every expected result has come
         while (pending_reqs.size() > 40) @(posedge clock);
         hold_sender = 1;
         while (expected_rsps.size() != 0 || req_tvalid) @(posedge clock);
         hold_sender = 0;
         add_random(95);
         wait_drained();
      end
      $display("covered %0d results over 5 register settings with clears, invalid and",
               rsp_seen);
      $display("near-zero samples, saturation extremes and full window wraparound");
      if (errors == 0) $display("** ph_sample_median_window_unit: PASSED **");
      else $display("** ph_sample_median_window_unit: FAILED **");
      $finish;
   end

   initial begin
      #30ms;
      $display("timeout");
      $display("** ph_sample_median_window_unit: FAILED **");
      $finish;
   end
endmodule

// ----- filelist.f -----
+incdir+design
design/psm_pkg.sv
design/psm_ram.sv
design/psm_result.sv
design/ph_sample_median_window_unit.sv
verif/testbench.sv
